### sv/pbaa_pkg.sv
// pbaa_pkg: shared types, widths and constants for the pressure block average alarm
// used by every module of the block; depends on nothing
`default_nettype none

package pbaa_pkg;

   // fixed field widths
   localparam int CODE_W   = 12;
   localparam int AVG_W    = 20;
   localparam int VALUE_W  = 24;
   localparam int CFG_W    = 24;
   localparam int CSR_A_W  = 3;
   localparam int CNT_CFG_W = 6;
   localparam int SCALE_W  = 12;
   localparam int ALU_W    = 32;
   localparam int FRAC_W   = 8;

   // default store depth
   localparam int STORE_DEPTH_DEF = 32;

   // sample conditioning and unit scales
   localparam logic [CODE_W-1:0]  CODE_MASK = 12'hffc;
   localparam logic [CODE_W-1:0]  ZERO_CODE = 12'd62;
   localparam logic [SCALE_W-1:0] SCALE_BAR = 12'd277;
   localparam logic [SCALE_W-1:0] SCALE_PSI = 12'd4017;

   // register indexes on the csr port
   typedef enum logic [CSR_A_W-1:0] {
      REG_AVG_COUNT  = 3'd0,
      REG_PSI_SELECT = 3'd1,
      REG_MODE_ONE   = 3'd2,
      REG_MODE_TWO   = 3'd3,
      REG_LOW_ONE    = 3'd4,
      REG_HIGH_ONE   = 3'd5,
      REG_LOW_TWO    = 3'd6,
      REG_HIGH_TWO   = 3'd7
   } csr_index_type;

   // alarm comparator modes
   typedef enum logic [1:0] {
      ALARM_BELOW   = 2'd0,
      ALARM_ABOVE   = 2'd1,
      ALARM_INSIDE  = 2'd2,
      ALARM_OUTSIDE = 2'd3
   } alarm_mode_type;

   // shared adder control
   typedef struct packed {
      logic sub;
   } alu_op_type;

endpackage

`default_nettype wire

### sv/pressure_block_average_alarm.sv
// pressure_block_average_alarm: sequencer, registers and result stage of the block
// depends on pbaa_pkg, pbaa_alu, pbaa_store and pbaa_alarm
//
//   channel | ports                          | direction | beat
//   req     | req_valid/ready, adc_sample    | in        | one converter sample
//   rsp     | rsp_valid/ready, five fields   | out       | one result per sample
//   csr     | csr_we, csr_addr, csr_wdata    | in        | one register write
//
// Each sample reduces the store index by repeated subtraction through the shared adder,
// which is needed only right after a block closes or after the average count shrinks;
// a sample that closes a block also sums the block's stored codes and divides the sum
// by n, the average count.
// The result waits in an output register; the next sample is taken meanwhile, and the
// sequencer only holds in its final step while that register is still full.
// Reset is synchronous; the sample memory is not cleared.
`default_nettype none

module pressure_block_average_alarm #(
   parameter int STORE_DEPTH = pbaa_pkg::STORE_DEPTH_DEF
) (
   input  var logic                           clock,
   input  var logic                           reset,
   input  var logic                           req_valid,
   output var logic                           req_ready,
   input  var logic [pbaa_pkg::CODE_W-1:0]    req_adc_sample,
   output var logic                           rsp_valid,
   input  var logic                           rsp_ready,
   output var logic [pbaa_pkg::VALUE_W-1:0]   rsp_pressure_value,
   output var logic                           rsp_below_zero,
   output var logic                           rsp_alarm_one,
   output var logic                           rsp_alarm_two,
   output var logic                           rsp_average_updated,
   input  var logic                           csr_we,
   input  var logic [pbaa_pkg::CSR_A_W-1:0]   csr_addr,
   input  var logic [pbaa_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int N_W   = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W = pbaa_pkg::CODE_W + IDX_W;
   localparam int DV_W  = SUM_W + pbaa_pkg::FRAC_W;
   localparam int CNT_W = $clog2(DV_W + STORE_DEPTH + 1);
   localparam int ALU_W = pbaa_pkg::ALU_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MOD   = 7'b0000010,
      ST_WRITE = 7'b0000100,
      ST_SUM   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_MUL   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // configuration registers
   logic [pbaa_pkg::CNT_CFG_W-1:0] avg_count_ff;
   logic                           psi_select_ff;
   pbaa_pkg::alarm_mode_type       mode_one_ff;
   pbaa_pkg::alarm_mode_type       mode_two_ff;
   logic [pbaa_pkg::CFG_W-1:0]     low_one_ff;
   logic [pbaa_pkg::CFG_W-1:0]     high_one_ff;
   logic [pbaa_pkg::CFG_W-1:0]     low_two_ff;
   logic [pbaa_pkg::CFG_W-1:0]     high_two_ff;

   // sequencer and datapath registers
   state_type                      state_ff, state_in;
   logic [N_W-1:0]                 store_index_ff, store_index_in;
   logic [pbaa_pkg::AVG_W-1:0]     held_ff, held_in;
   logic                           below_ff, below_in;
   logic [pbaa_pkg::CODE_W-1:0]    mag_ff, mag_in;
   logic [N_W-1:0]                 n_ff, n_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic [ALU_W-1:0]               acc_ff, acc_in;
   logic [DV_W-1:0]                quo_ff, quo_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [pbaa_pkg::SCALE_W-1:0]   scale_ff, scale_in;
   logic                           updated_ff, updated_in;
   logic [pbaa_pkg::VALUE_W-1:0]   value_ff, value_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pbaa_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                           rsp_below_ff, rsp_below_in;
   logic                           rsp_alarm_one_ff, rsp_alarm_one_in;
   logic                           rsp_alarm_two_ff, rsp_alarm_two_in;
   logic                           rsp_updated_ff, rsp_updated_in;

   // shared unit, memory and comparator nets
   pbaa_pkg::alu_op_type           alu_op;
   logic [ALU_W-1:0]               alu_a;
   logic [ALU_W-1:0]               alu_b;
   logic [ALU_W-1:0]               alu_y;
   logic                           alu_carry;
   logic                           wr_en;
   logic [pbaa_pkg::CODE_W-1:0]    rd_data;
   logic                           alarm_one;
   logic                           alarm_two;

   // sample conditioning
   logic [pbaa_pkg::CODE_W-1:0]    code;
   logic                           code_below;
   logic [N_W:0]                   trial;

   assign code       = req_adc_sample & pbaa_pkg::CODE_MASK;
   assign code_below = code < pbaa_pkg::ZERO_CODE;
   assign trial      = {acc_ff[N_W-1:0], quo_ff[DV_W-1]};

   assign req_ready = (state_ff == ST_IDLE);

   pbaa_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .y     (alu_y),
      .carry (alu_carry)
   );

   pbaa_store #(.DEPTH(STORE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (mag_ff),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   pbaa_alarm u_alarm_one (
      .mode  (mode_one_ff),
      .value (value_ff),
      .low   (low_one_ff),
      .high  (high_one_ff),
      .alarm (alarm_one)
   );

   pbaa_alarm u_alarm_two (
      .mode  (mode_two_ff),
      .value (value_ff),
      .low   (low_two_ff),
      .high  (high_two_ff),
      .alarm (alarm_two)
   );

   // sequencer next state and datapath steering
   always_comb begin
      state_in         = state_ff;
      store_index_in   = store_index_ff;
      held_in          = held_ff;
      below_in         = below_ff;
      mag_in           = mag_ff;
      n_in             = n_ff;
      idx_in           = idx_ff;
      acc_in           = acc_ff;
      quo_in           = quo_ff;
      cnt_in           = cnt_ff;
      scale_in         = scale_ff;
      updated_in       = updated_ff;
      value_in         = value_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_value_in     = rsp_value_ff;
      rsp_below_in     = rsp_below_ff;
      rsp_alarm_one_in = rsp_alarm_one_ff;
      rsp_alarm_two_in = rsp_alarm_two_ff;
      rsp_updated_in   = rsp_updated_ff;
      alu_op.sub       = 1'b0;
      alu_a            = '0;
      alu_b            = '0;
      wr_en            = 1'b0;

      case (state_ff)
         // take a sample, condition it and clamp the block length
         ST_IDLE: begin
            if (req_valid) begin
               below_in = code_below;
               mag_in   = code_below ? (pbaa_pkg::ZERO_CODE - code) : code;
               if (avg_count_ff == '0) begin
                  n_in = N_W'(1);
               end else if (32'(avg_count_ff) > 32'(STORE_DEPTH)) begin
                  n_in = N_W'(STORE_DEPTH);
               end else begin
                  n_in = N_W'(avg_count_ff);
               end
               acc_in   = ALU_W'(store_index_ff);
               state_in = ST_MOD;
            end
         end

         // reduce the store index by repeated subtraction
         ST_MOD: begin
            alu_op.sub = 1'b1;
            alu_a      = acc_ff;
            alu_b      = ALU_W'(n_ff);
            if (alu_carry) begin
               acc_in = alu_y;
            end else begin
               idx_in   = acc_ff[IDX_W-1:0];
               state_in = ST_WRITE;
            end
         end

         // store the code, decide whether the block is complete
         ST_WRITE: begin
            wr_en          = 1'b1;
            store_index_in = N_W'(idx_ff) + N_W'(1);
            scale_in       = psi_select_ff ? pbaa_pkg::SCALE_PSI : pbaa_pkg::SCALE_BAR;
            acc_in         = '0;
            cnt_in         = '0;
            if (N_W'(idx_ff) == n_ff - N_W'(1)) begin
               updated_in = 1'b1;
               state_in   = ST_SUM;
            end else begin
               updated_in = 1'b0;
               state_in   = ST_MUL;
            end
         end

         // accumulate stored codes, read data arrives in the cycle after its address
         ST_SUM: begin
            alu_a  = acc_ff;
            alu_b  = (cnt_ff == '0) ? '0 : ALU_W'(rd_data);
            acc_in = alu_y;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(n_ff)) begin
               quo_in   = {alu_y[SUM_W-1:0], pbaa_pkg::FRAC_W'(0)};
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end

         // restoring divide of sum * 256 by n, one quotient bit a cycle
         ST_DIV: begin
            alu_op.sub = 1'b1;
            alu_a      = ALU_W'(trial);
            alu_b      = ALU_W'(n_ff);
            acc_in     = alu_carry ? alu_y : ALU_W'(trial);
            quo_in     = {quo_ff[DV_W-2:0], alu_carry};
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DV_W - 1)) begin
               held_in  = {quo_ff[pbaa_pkg::AVG_W-2:0], alu_carry};
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end

         // shift-add scaling of the held average, scale msb first
         ST_MUL: begin
            alu_a    = {acc_ff[ALU_W-2:0], 1'b0};
            alu_b    = scale_ff[pbaa_pkg::SCALE_W-1] ? ALU_W'(held_ff) : '0;
            acc_in   = alu_y;
            scale_in = {scale_ff[pbaa_pkg::SCALE_W-2:0], 1'b0};
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(pbaa_pkg::SCALE_W - 1)) begin
               value_in = alu_y[pbaa_pkg::VALUE_W+pbaa_pkg::FRAC_W-1:pbaa_pkg::FRAC_W];
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end

         // load the result register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_value_in     = value_ff;
               rsp_below_in     = below_ff;
               rsp_alarm_one_in = alarm_one;
               rsp_alarm_two_in = alarm_two;
               rsp_updated_in   = updated_ff;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         store_index_ff <= '0;
         held_ff        <= '0;
         below_ff       <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         store_index_ff <= store_index_in;
         held_ff        <= held_in;
         below_ff       <= below_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      n_ff             <= n_in;
      idx_ff           <= idx_in;
      acc_ff           <= acc_in;
      quo_ff           <= quo_in;
      scale_ff         <= scale_in;
      updated_ff       <= updated_in;
      value_ff         <= value_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_below_ff     <= rsp_below_in;
      rsp_alarm_one_ff <= rsp_alarm_one_in;
      rsp_alarm_two_ff <= rsp_alarm_two_in;
      rsp_updated_ff   <= rsp_updated_in;
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_count_ff  <= pbaa_pkg::CNT_CFG_W'(1);
         psi_select_ff <= 1'b0;
         mode_one_ff   <= pbaa_pkg::ALARM_BELOW;
         mode_two_ff   <= pbaa_pkg::ALARM_BELOW;
         low_one_ff    <= '0;
         high_one_ff   <= '0;
         low_two_ff    <= '0;
         high_two_ff   <= '0;
      end else if (csr_we) begin
         case (pbaa_pkg::csr_index_type'(csr_addr))
            pbaa_pkg::REG_AVG_COUNT:  avg_count_ff  <= csr_wdata[pbaa_pkg::CNT_CFG_W-1:0];
            pbaa_pkg::REG_PSI_SELECT: psi_select_ff <= csr_wdata[0];
            pbaa_pkg::REG_MODE_ONE:   mode_one_ff   <= pbaa_pkg::alarm_mode_type'(csr_wdata[1:0]);
            pbaa_pkg::REG_MODE_TWO:   mode_two_ff   <= pbaa_pkg::alarm_mode_type'(csr_wdata[1:0]);
            pbaa_pkg::REG_LOW_ONE:    low_one_ff    <= csr_wdata;
            pbaa_pkg::REG_HIGH_ONE:   high_one_ff   <= csr_wdata;
            pbaa_pkg::REG_LOW_TWO:    low_two_ff    <= csr_wdata;
            pbaa_pkg::REG_HIGH_TWO:   high_two_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pressure_value  = rsp_value_ff;
   assign rsp_below_zero      = rsp_below_ff;
   assign rsp_alarm_one       = rsp_alarm_one_ff;
   assign rsp_alarm_two       = rsp_alarm_two_ff;
   assign rsp_average_updated = rsp_updated_ff;

`ifndef ASSERT_OFF
   // an accepted beat always starts the index reduction
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MOD))
      else $error("accepted sample did not start index reduction");

   // the reduced index lies inside the current block
   a_idx_in_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (N_W'(idx_ff) < n_ff))
      else $error("store index not reduced below block length");

   // the summing count never exceeds the block length
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (cnt_ff <= CNT_W'(n_ff)))
      else $error("summing count beyond block length");

   // the divide step count stays below the quotient width
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < CNT_W'(DV_W)))
      else $error("divide step count overran");

   // a full result register is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### sv/pbaa_alu.sv
// pbaa_alu: the one shared add/subtract unit of the block
// depends on pbaa_pkg for width and control struct
`default_nettype none

module pbaa_alu (
   input  var pbaa_pkg::alu_op_type         op,
   input  var logic [pbaa_pkg::ALU_W-1:0]   a,
   input  var logic [pbaa_pkg::ALU_W-1:0]   b,
   output var logic [pbaa_pkg::ALU_W-1:0]   y,
   output var logic                         carry
);

   logic [pbaa_pkg::ALU_W:0]   sum;
   logic [pbaa_pkg::ALU_W-1:0] b_eff;

   // subtract as add of inverted operand; carry out means a >= b
   assign b_eff = op.sub ? ~b : b;
   assign sum   = {1'b0, a} + {1'b0, b_eff} + (pbaa_pkg::ALU_W + 1)'(op.sub);
   assign y     = sum[pbaa_pkg::ALU_W-1:0];
   assign carry = sum[pbaa_pkg::ALU_W];

endmodule

`default_nettype wire

### sv/pbaa_store.sv
// pbaa_store: sample code memory, one write and one registered read port
// depends on pbaa_pkg for the code width
`default_nettype none

module pbaa_store #(
   parameter int DEPTH = pbaa_pkg::STORE_DEPTH_DEF
) (
   input  var logic                        clock,
   input  var logic                        wr_en,
   input  var logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  var logic [pbaa_pkg::CODE_W-1:0] wr_data,
   input  var logic [$clog2(DEPTH)-1:0]    rd_addr,
   output var logic [pbaa_pkg::CODE_W-1:0] rd_data
);

   logic [pbaa_pkg::CODE_W-1:0] mem [DEPTH];
   logic [pbaa_pkg::CODE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/pbaa_alarm.sv
// pbaa_alarm: strict window comparator for one alarm channel
// depends on pbaa_pkg for the mode codes and widths
`default_nettype none

module pbaa_alarm (
   input  var pbaa_pkg::alarm_mode_type      mode,
   input  var logic [pbaa_pkg::VALUE_W-1:0]  value,
   input  var logic [pbaa_pkg::CFG_W-1:0]    low,
   input  var logic [pbaa_pkg::CFG_W-1:0]    high,
   output var logic                          alarm
);

   logic under;
   logic over;

   assign under = value < low;
   assign over  = value > high;

   // mode select, all compares strict
   always_comb begin
      case (mode)
         pbaa_pkg::ALARM_BELOW:   alarm = under;
         pbaa_pkg::ALARM_ABOVE:   alarm = over;
         pbaa_pkg::ALARM_INSIDE:  alarm = (value > low) && (value < high);
         pbaa_pkg::ALARM_OUTSIDE: alarm = under || over;
         default:                 alarm = 1'b0;
      endcase
   end

endmodule

`default_nettype wire
